>>> src/pot_and_button_input_conditioner_defines.svh
// Assertion macros used by the checker file of the input conditioner.
`ifndef POT_AND_BUTTON_INPUT_CONDITIONER_DEFINES_SVH
`define POT_AND_BUTTON_INPUT_CONDITIONER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PBIC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbic: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PBIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbic: next-cycle check failed");

`endif

>>> src/pbic_pkg.sv
// Types and constants of the pot and button input conditioner.
package pbic_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EMA_NUM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_DEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_LEVEL = 3'd4;

  // 12-bit converter; cursor and zone arithmetic in the datapath assume this value
  localparam int unsigned ADC_FULL_SCALE = 4095;

  // EMA divider: weighted sum reaches 31 * 4095 (17 bits), divisor up to 31.
  localparam int unsigned DIV_DVD_W = 17;
  localparam int unsigned DIV_DVS_W = 5;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [DIV_CNT_W-1:0] EMA_ITERS = 5'd17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EGO,
    S_EDIV,
    S_UPD,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_go;
    logic update;
    logic load_out;
  } dp_cmd_t;

endpackage

>>> src/pbic_div.sv
// Restoring divider, one quotient bit per cycle, used for the EMA division.
module pbic_div import pbic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_DVD_W-1:0] dividend_i,
  input  logic [DIV_DVS_W-1:0] divisor_i,
  input  logic [DIV_CNT_W-1:0] iters_i,
  output logic [DIV_DVD_W-1:0] quotient_o,
  output logic                 done_o
);

  logic [DIV_DVD_W-1:0] work_q, work_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W-1:0] dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DVS_W:0]   trial;
  logic                 fits;

  // Dividend bits leave at the top, quotient bits enter at the bottom.
  assign trial = {rem_q, work_q[DIV_DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = fits ? DIV_DVS_W'(trial - {1'b0, dvs_q}) : trial[DIV_DVS_W-1:0];
    work_d = {work_q[DIV_DVD_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= iters_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign quotient_o = work_q;
  assign done_o     = cnt_q == '0;

endmodule

>>> src/pbic_dp.sv
// Datapath: config registers, filter state, debounce, click latch, result register.
module pbic_dp import pbic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [31:0]           now_time_i,
  input  logic [11:0]           adc_sample_i,
  input  logic                  button_level_i,
  input  logic                  diag_level_i,
  input  logic [7:0]            zone_count_i,
  input  logic                  take_click_i,
  input  dp_cmd_t               cmd_i,
  output logic                  div_done_o,
  output logic [11:0]           smoothed_level_o,
  output logic [15:0]           cursor_position_o,
  output logic                  at_left_o,
  output logic                  at_right_o,
  output logic [31:0]           edge_change_time_o,
  output logic                  button_pressed_o,
  output logic                  diag_active_o,
  output logic [7:0]            zone_index_o,
  output logic                  clicked_o,
  output logic [31:0]           last_click_time_o
);

  localparam logic [11:0] FS      = 12'(ADC_FULL_SCALE);
  localparam logic [11:0] LO_EDGE = 12'(ADC_FULL_SCALE / 20);
  localparam logic [11:0] HI_EDGE = 12'(ADC_FULL_SCALE - ADC_FULL_SCALE / 20);
  // 65535 / 4095 = 16 + 1/273; level * 3841 >> 20 gives floor(level / 273) exactly
  // for every 12-bit level
  localparam logic [11:0] CUR_RECIP = 12'd3841;

  // config
  logic [3:0]  ema_num_q;
  logic [4:0]  ema_den_q;
  logic [15:0] debounce_q;
  logic        btn_lvl_q;
  logic        diag_lvl_q;

  // captured item
  logic [31:0] now_q;
  logic [11:0] sample_q;
  logic        btn_q;
  logic        diag_q;
  logic [7:0]  zones_q;
  logic        take_q;

  // filter and button state
  logic [11:0] avg_q;
  logic        seeded_q;
  logic        left_q, right_q;
  logic [31:0] edge_q;
  logic        stable_q;
  logic [31:0] change_q;
  logic        click_q;
  logic [31:0] press_q;
  logic        clicked_q;

  logic [16:0] sum_q;

  // result register
  logic [11:0] res_level_q;
  logic [15:0] res_cursor_q;
  logic        res_left_q, res_right_q;
  logic [31:0] res_edge_q;
  logic        res_pressed_q;
  logic        res_diag_q;
  logic [7:0]  res_zone_q;
  logic        res_clicked_q;
  logic [31:0] res_click_time_q;

  logic [4:0]           den_eff, num_eff;
  logic [16:0]          prod_a, prod_b;
  logic [19:0]          zone_prod;
  logic [23:0]          cur_prod;
  logic [15:0]          cursor_val;
  logic [DIV_DVD_W-1:0] quot;

  logic [11:0] ema_clamp, seed_clamp, avg_new;
  logic        lo_hit, hi_hit;
  logic        pressed;
  logic [31:0] elapsed;
  logic        click_set;
  logic [7:0]  zone_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_num_q  <= 4'd1;
      ema_den_q  <= 5'd4;
      debounce_q <= 16'd50;
      btn_lvl_q  <= 1'b0;
      diag_lvl_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EMA_NUM:    ema_num_q  <= cfg_data_i[3:0];
        CFG_EMA_DEN:    ema_den_q  <= cfg_data_i[4:0];
        CFG_DEBOUNCE:   debounce_q <= cfg_data_i;
        CFG_BTN_LEVEL:  btn_lvl_q  <= cfg_data_i[0];
        CFG_DIAG_LEVEL: diag_lvl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q    <= now_time_i;
      sample_q <= adc_sample_i;
      btn_q    <= button_level_i;
      diag_q   <= diag_level_i;
      zones_q  <= zone_count_i;
      take_q   <= take_click_i;
    end
  end

  // EMA weights: zero denominator acts as one, numerator capped at denominator
  assign den_eff = (ema_den_q == 5'd0) ? 5'd1 : ema_den_q;
  assign num_eff = ({1'b0, ema_num_q} > den_eff) ? den_eff : {1'b0, ema_num_q};
  assign prod_a  = 17'(num_eff) * 17'(sample_q);
  assign prod_b  = 17'(den_eff - num_eff) * 17'(avg_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      sum_q <= prod_a + prod_b;
    end
  end

  pbic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (sum_q),
    .divisor_i  (den_eff),
    .iters_i    (EMA_ITERS),
    .quotient_o (quot),
    .done_o     (div_done_o)
  );

  always_comb begin
    ema_clamp  = (quot > 17'(FS)) ? FS : quot[11:0];
    seed_clamp = (sample_q > FS) ? FS : sample_q;
    avg_new    = seeded_q ? ema_clamp : seed_clamp;
    lo_hit     = avg_new <= LO_EDGE;
    hi_hit     = avg_new >= HI_EDGE;
    pressed    = btn_q == btn_lvl_q;
    elapsed    = now_q - change_q;       // wraps cleanly modulo 2^32
    click_set  = click_q;
    if (pressed != stable_q && elapsed >= {16'd0, debounce_q} && pressed) begin
      click_set = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q     <= '0;
      seeded_q  <= 1'b0;
      left_q    <= 1'b1;
      right_q   <= 1'b0;
      edge_q    <= '0;
      stable_q  <= 1'b0;
      change_q  <= '0;
      click_q   <= 1'b0;
      press_q   <= '0;
      clicked_q <= 1'b0;
    end else if (cmd_i.update) begin
      avg_q    <= avg_new;
      seeded_q <= 1'b1;
      left_q   <= lo_hit;
      right_q  <= hi_hit;
      if (lo_hit != left_q || hi_hit != right_q) begin
        edge_q <= now_q;
      end
      // any raw change restarts the window, accepted or not
      if (pressed != stable_q) begin
        change_q <= now_q;
        if (elapsed >= {16'd0, debounce_q}) begin
          stable_q <= pressed;
          if (pressed) begin
            press_q <= now_q;
          end
        end
      end
      click_q   <= click_set && !take_q;
      clicked_q <= click_set && take_q;
    end
  end

  // cursor = level * 65535 / 4095 = level * 16 + floor(level / 273)
  assign cur_prod   = 24'(avg_q) * 24'(CUR_RECIP);
  assign cursor_val = {avg_q, 4'd0} + 16'(cur_prod[23:20]);

  // zone = level * zones / 4096
  assign zone_prod = 20'(avg_q) * 20'(zones_q);

  always_comb begin
    if (zones_q == 8'd0) begin
      zone_val = 8'd0;
    end else if (zone_prod[19:12] >= zones_q) begin
      zone_val = zones_q - 8'd1;
    end else begin
      zone_val = zone_prod[19:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_level_q      <= avg_q;
      res_cursor_q     <= cursor_val;
      res_left_q       <= left_q;
      res_right_q      <= right_q;
      res_edge_q       <= edge_q;
      res_pressed_q    <= stable_q;
      res_diag_q       <= diag_q == diag_lvl_q;
      res_zone_q       <= zone_val;
      res_clicked_q    <= clicked_q;
      res_click_time_q <= press_q;
    end
  end

  assign smoothed_level_o   = res_level_q;
  assign cursor_position_o  = res_cursor_q;
  assign at_left_o          = res_left_q;
  assign at_right_o         = res_right_q;
  assign edge_change_time_o = res_edge_q;
  assign button_pressed_o   = res_pressed_q;
  assign diag_active_o      = res_diag_q;
  assign zone_index_o       = res_zone_q;
  assign clicked_o          = res_clicked_q;
  assign last_click_time_o  = res_click_time_q;

endmodule

>>> src/pbic_ctrl.sv
// Sequencer: steps one item through multiply, EMA division, update and result load.
module pbic_ctrl import pbic_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    div_done_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_EGO;
      S_EGO:  state_d = S_EDIV;
      S_EDIV: if (div_done_i) state_d = S_UPD;
      S_UPD:  state_d = S_FIN;
      S_FIN:  if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_MUL:  cmd_o.mul = 1'b1;
      S_EGO:  cmd_o.div_go = 1'b1;
      S_UPD:  cmd_o.update = 1'b1;
      S_FIN:  cmd_o.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/pot_and_button_input_conditioner.sv
// Top level of the pot and button input conditioner.
//
//   channel | signals                      | direction | notes
//   in      | in_valid_i / in_ready_o      | sink      | one tick item
//   out     | out_valid_o / out_ready_i    | source    | one result item per tick
//   cfg     | cfg_valid_i / cfg_ready_o    | sink      | index + data, always ready
//
// One item at a time: each item passes through five sequencing steps and the
// one-bit-per-cycle EMA divider (17 iterations), which holds the sequencer until done.
// A finished result sits in the output register; the next item is accepted meanwhile
// and waits at its last step only if that register is still full.
// Reset is asynchronous, active low, and needs no clearing pass.
module pot_and_button_input_conditioner import pbic_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [31:0]           now_time_i,
  input  logic [11:0]           adc_sample_i,
  input  logic                  button_level_i,
  input  logic                  diag_level_i,
  input  logic [7:0]            zone_count_i,
  input  logic                  take_click_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [11:0]           smoothed_level_o,
  output logic [15:0]           cursor_position_o,
  output logic                  at_left_o,
  output logic                  at_right_o,
  output logic [31:0]           edge_change_time_o,
  output logic                  button_pressed_o,
  output logic                  diag_active_o,
  output logic [7:0]            zone_index_o,
  output logic                  clicked_o,
  output logic [31:0]           last_click_time_o
);

  dp_cmd_t cmd;
  logic    div_done;

  assign cfg_ready_o = 1'b1;

  pbic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .div_done_i  (div_done),
    .cmd_o       (cmd)
  );

  pbic_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .now_time_i         (now_time_i),
    .adc_sample_i       (adc_sample_i),
    .button_level_i     (button_level_i),
    .diag_level_i       (diag_level_i),
    .zone_count_i       (zone_count_i),
    .take_click_i       (take_click_i),
    .cmd_i              (cmd),
    .div_done_o         (div_done),
    .smoothed_level_o   (smoothed_level_o),
    .cursor_position_o  (cursor_position_o),
    .at_left_o          (at_left_o),
    .at_right_o         (at_right_o),
    .edge_change_time_o (edge_change_time_o),
    .button_pressed_o   (button_pressed_o),
    .diag_active_o      (diag_active_o),
    .zone_index_o       (zone_index_o),
    .clicked_o          (clicked_o),
    .last_click_time_o  (last_click_time_o)
  );

endmodule

>>> src/pbic_chk.sv
// Port-level checker for the input conditioner and its bind.
`include "pot_and_button_input_conditioner_defines.svh"

module pbic_chk import pbic_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] smoothed_level_o,
  input logic [15:0] cursor_position_o,
  input logic        at_left_o,
  input logic        at_right_o
);

  localparam logic [11:0] LOW_EDGE = 12'(ADC_FULL_SCALE / 20);

  logic [27:0] out_word;

  assign out_word = {smoothed_level_o, cursor_position_o};

  `PBIC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))
  `PBIC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `PBIC_ASSERT_IMPL(a_flags_exclusive, out_valid_o, !(at_left_o && at_right_o))
  `PBIC_ASSERT_IMPL(a_left_range, out_valid_o && at_left_o, smoothed_level_o <= LOW_EDGE)

endmodule

bind pot_and_button_input_conditioner pbic_chk u_pbic_chk (.*);

>>> sim/testbench.sv
// Testbench for the pot and button input conditioner: ticks in, predicted readings checked.
`timescale 1ns / 100ps

module testbench;
  import pbic_pkg::*;

  localparam int unsigned FULL_SCALE  = 4095;
  localparam int unsigned LOW_LIMIT   = FULL_SCALE / 20;
  localparam int unsigned HIGH_LIMIT  = FULL_SCALE - LOW_LIMIT;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic [31:0] now;
    logic [11:0] adc;
    logic        btn;
    logic        diag;
    logic [7:0]  zones;
    logic        take;
  } tick_t;

  typedef struct {
    logic [11:0] level;
    logic [15:0] cursor;
    logic        left;
    logic        right;
    logic [31:0] edge_stamp;
    logic        pressed;
    logic        diag_on;
    logic [7:0]  zone;
    logic        clicked;
    logic [31:0] press_stamp;
  } reading_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [31:0]           now_time_i = '0;
  logic [11:0]           adc_sample_i = '0;
  logic                  button_level_i = 1'b0;
  logic                  diag_level_i = 1'b0;
  logic [7:0]            zone_count_i = '0;
  logic                  take_click_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [11:0]           smoothed_level_o;
  logic [15:0]           cursor_position_o;
  logic                  at_left_o;
  logic                  at_right_o;
  logic [31:0]           edge_change_time_o;
  logic                  button_pressed_o;
  logic                  diag_active_o;
  logic [7:0]            zone_index_o;
  logic                  clicked_o;
  logic [31:0]           last_click_time_o;

  pot_and_button_input_conditioner dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .now_time_i, .adc_sample_i, .button_level_i,
    .diag_level_i, .zone_count_i, .take_click_i,
    .out_valid_o, .out_ready_i, .smoothed_level_o, .cursor_position_o,
    .at_left_o, .at_right_o, .edge_change_time_o, .button_pressed_o,
    .diag_active_o, .zone_index_o, .clicked_o, .last_click_time_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and state
  logic [3:0]  reg_ema_num = 4'd1;
  logic [4:0]  reg_ema_den = 5'd4;
  logic [15:0] reg_debounce = 16'd50;
  logic        reg_btn_level = 1'b0;
  logic        reg_diag_level = 1'b0;

  logic [11:0] avg_level = '0;
  logic        avg_primed = 1'b0;
  logic        left_hit = 1'b1;
  logic        right_hit = 1'b0;
  logic [31:0] edge_stamp = '0;
  logic        btn_state = 1'b0;
  logic [31:0] btn_change_stamp = '0;
  logic        click_armed = 1'b0;
  logic [31:0] press_stamp = '0;

  tick_t    pending_ticks[$];
  reading_t expected_readings[$];
  int unsigned ticks_queued = 0;
  int unsigned ticks_accepted = 0;
  int unsigned readings_seen = 0;
  int unsigned num_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 61;

  // stimulus generator state
  logic [31:0] gen_time = 32'd1000;
  logic [11:0] gen_adc = 12'd2048;
  logic        gen_btn = 1'b1;

  function automatic reading_t condition_tick(tick_t t);
    reading_t r;
    logic [4:0]  den;
    logic [4:0]  num;
    logic [31:0] wsum;
    logic [31:0] level;
    logic [31:0] zone;
    logic        near_left;
    logic        near_right;
    logic        pressed;
    den = (reg_ema_den == 5'd0) ? 5'd1 : reg_ema_den;
    num = ({1'b0, reg_ema_num} > den) ? den : {1'b0, reg_ema_num};
    if (!avg_primed) begin
      level = {20'd0, t.adc};
      avg_primed = 1'b1;
    end else begin
      wsum = num * t.adc + (den - num) * avg_level;
      level = wsum / den;
    end
    if (level > FULL_SCALE) level = FULL_SCALE;
    avg_level = level[11:0];

    near_left = level <= LOW_LIMIT;
    near_right = level >= HIGH_LIMIT;
    if (near_left != left_hit || near_right != right_hit) edge_stamp = t.now;
    left_hit = near_left;
    right_hit = near_right;

    // wrap-safe debounce; a rejected change still restarts the window
    pressed = (t.btn == reg_btn_level);
    if (pressed != btn_state) begin
      if (t.now - btn_change_stamp >= {16'd0, reg_debounce}) begin
        btn_state = pressed;
        if (pressed) begin
          click_armed = 1'b1;
          press_stamp = t.now;
        end
      end
      btn_change_stamp = t.now;
    end

    zone = 0;
    if (t.zones != 8'd0) begin
      zone = (level * t.zones) / (FULL_SCALE + 1);
      if (zone >= t.zones) zone = t.zones - 1;
    end

    r.clicked = 1'b0;
    if (t.take && click_armed) begin
      click_armed = 1'b0;
      r.clicked = 1'b1;
    end

    r.level = avg_level;
    r.cursor = 16'((level * 65535) / FULL_SCALE);
    r.left = left_hit;
    r.right = right_hit;
    r.edge_stamp = edge_stamp;
    r.pressed = btn_state;
    r.diag_on = (t.diag == reg_diag_level);
    r.zone = zone[7:0];
    r.press_stamp = press_stamp;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_EMA_NUM:    reg_ema_num = data[3:0];
      CFG_EMA_DEN:    reg_ema_den = data[4:0];
      CFG_DEBOUNCE:   reg_debounce = data[15:0];
      CFG_BTN_LEVEL:  reg_btn_level = data[0];
      CFG_DIAG_LEVEL: reg_diag_level = data[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      num_errors++;
    end
  endfunction

  // Driver: holds each item until accepted, predicts on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    tick_t seen;
    tick_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen.now = now_time_i;
        seen.adc = adc_sample_i;
        seen.btn = button_level_i;
        seen.diag = diag_level_i;
        seen.zones = zone_count_i;
        seen.take = take_click_i;
        expected_readings.push_back(condition_tick(seen));
        ticks_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ticks.pop_front();
          in_valid_i <= 1'b1;
          now_time_i <= nxt.now;
          adc_sample_i <= nxt.adc;
          button_level_i <= nxt.btn;
          diag_level_i <= nxt.diag;
          zone_count_i <= nxt.zones;
          take_click_i <= nxt.take;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each taken reading with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : reading_monitor
    reading_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $error("reading with no tick outstanding");
          num_errors++;
        end else begin
          want = expected_readings.pop_front();
          check_field("smoothed_level", want.level, smoothed_level_o);
          check_field("cursor_position", want.cursor, cursor_position_o);
          check_field("at_left", want.left, at_left_o);
          check_field("at_right", want.right, at_right_o);
          check_field("edge_change_time", want.edge_stamp, edge_change_time_o);
          check_field("button_pressed", want.pressed, button_pressed_o);
          check_field("diag_active", want.diag_on, diag_active_o);
          check_field("zone_index", want.zone, zone_index_o);
          check_field("clicked", want.clicked, clicked_o);
          check_field("last_click_time", want.press_stamp, last_click_time_o);
        end
        readings_seen++;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_tick(logic [31:0] now, logic [11:0] adc, logic btn, logic diag,
                          logic [7:0] zones, logic take);
    tick_t t;
    t.now = now;
    t.adc = adc;
    t.btn = btn;
    t.diag = diag;
    t.zones = zones;
    t.take = take;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || readings_seen != ticks_accepted)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] num, logic [15:0] den, logic [15:0] deb,
                           logic [15:0] btn, logic [15:0] diag);
    write_reg(CFG_EMA_NUM, num);
    write_reg(CFG_EMA_DEN, den);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_BTN_LEVEL, btn);
    write_reg(CFG_DIAG_LEVEL, diag);
  endtask

  // Mostly slowly moving time, a level that walks or jumps, and button toggles
  task automatic add_random_ticks(int n);
    int          v;
    int unsigned pick;
    logic [7:0]  zones;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) gen_time = gen_time + $urandom_range(0, 2 * reg_debounce + 2);
      else if (pick < 90) gen_time = gen_time + $urandom();
      else gen_time = gen_time + $urandom_range(0, 1);

      pick = $urandom_range(99);
      if (pick < 40) begin
        v = int'(gen_adc) + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        gen_adc = 12'(v);
      end else if (pick < 60) begin
        gen_adc = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      end else begin
        gen_adc = 12'($urandom());
      end

      if ($urandom_range(99) < 30) gen_btn = ~gen_btn;

      pick = $urandom_range(99);
      if (pick < 10) zones = 8'd0;
      else if (pick < 20) zones = 8'd255;
      else if (pick < 30) zones = 8'd1;
      else zones = 8'($urandom_range(1, 255));

      add_tick(gen_time, gen_adc, gen_btn, 1'($urandom()), zones, 1'($urandom()));
    end
  endtask

  task automatic write_random_config();
    logic [15:0] deb;
    deb = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom());
    write_all(16'($urandom()), 16'($urandom()), deb, 16'($urandom()), 16'($urandom()));
    write_reg(CFG_UNUSED_IDX, 16'($urandom()));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: seed, debounce window, release, click, zone extremes, time wrap
    add_tick(32'd100, 12'hFFF, 1'b1, 1'b0, 8'd255, 1'b0);
    add_tick(32'd110, 12'h000, 1'b0, 1'b1, 8'd1, 1'b1);
    add_tick(32'd120, 12'h000, 1'b1, 1'b0, 8'd0, 1'b1);
    add_tick(32'd200, 12'h000, 1'b1, 1'b1, 8'd128, 1'b1);
    add_tick(32'd210, 12'h000, 1'b0, 1'b0, 8'd2, 1'b0);
    add_tick(32'd300, 12'h000, 1'b0, 1'b1, 8'd255, 1'b0);
    add_tick(32'd301, 12'h000, 1'b0, 1'b0, 8'd255, 1'b1);
    for (int i = 0; i < 6; i++)
      add_tick(32'd400 + i * 10, 12'h000, i[0], i[1], 8'(255 - i), 1'b1);
    add_tick(32'hFFFF_FFC0, 12'hFFF, 1'b1, 1'b0, 8'd255, 1'b0);
    add_tick(32'h0000_0010, 12'hFFF, 1'b0, 1'b1, 8'd0, 1'b0);
    add_tick(32'h0000_0020, 12'h800, 1'b1, 1'b0, 8'd3, 1'b1);
    add_tick(32'h0000_0060, 12'h800, 1'b1, 1'b1, 8'd255, 1'b1);
    add_tick(32'h0000_0060, 12'h800, 1'b0, 1'b0, 8'd7, 1'b0);
    add_tick(32'hFFFF_FFFF, 12'hFFF, 1'b0, 1'b1, 8'd255, 1'b1);
    wait_drained();

    // zero numerator and zero denominator, no debounce, active-high pins
    write_all(16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    add_random_ticks(220);
    wait_drained();

    gen_time = 32'hFFFF_0000;
    write_all(16'd15, 16'd16, 16'hFFFF, 16'd0, 16'd1);
    add_random_ticks(220);
    wait_drained();

    // numerator above denominator
    write_all(16'd15, 16'd3, 16'd10, 16'd1, 16'd0);
    add_random_ticks(240);
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 27;
    write_all(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    add_random_ticks(240);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      write_random_config();
      add_random_ticks(240);
      wait_drained();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_random_config();
    add_random_ticks(240);
    wait_drained();

    write_all(16'd7, 16'd31, 16'd100, 16'($urandom()), 16'($urandom()));
    add_random_ticks(220);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (num_errors == 0 && expected_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/pbic_pkg.sv
src/pbic_div.sv
src/pbic_dp.sv
src/pbic_ctrl.sv
src/pot_and_button_input_conditioner.sv
src/pbic_chk.sv
sim/testbench.sv
